### rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, constants and the decimal segment code table of the
// seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned DIGITS_DEF = 8;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned START_W = 3;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned SEL_W   = 8;
  localparam int unsigned SEG_W   = 8;
  localparam int unsigned REM_W   = 4;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_NUMBER = 1'b1;

  localparam logic [SEG_W-1:0] BLANK_CODE = 8'hFF;

  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned        DIV10_SHIFT = 35;

  localparam logic [REM_W-1:0] DEC_0 = 4'd0;
  localparam logic [REM_W-1:0] DEC_1 = 4'd1;
  localparam logic [REM_W-1:0] DEC_2 = 4'd2;
  localparam logic [REM_W-1:0] DEC_3 = 4'd3;
  localparam logic [REM_W-1:0] DEC_4 = 4'd4;
  localparam logic [REM_W-1:0] DEC_5 = 4'd5;
  localparam logic [REM_W-1:0] DEC_6 = 4'd6;
  localparam logic [REM_W-1:0] DEC_7 = 4'd7;
  localparam logic [REM_W-1:0] DEC_8 = 4'd8;
  localparam logic [REM_W-1:0] DEC_9 = 4'd9;

  function automatic logic [SEG_W-1:0] digit_code(input logic [REM_W-1:0] dec);
    logic [SEG_W-1:0] code;
    case (dec)
      DEC_0:   code = 8'hC0;
      DEC_1:   code = 8'hF9;
      DEC_2:   code = 8'hA4;
      DEC_3:   code = 8'hB0;
      DEC_4:   code = 8'h99;
      DEC_5:   code = 8'h92;
      DEC_6:   code = 8'h82;
      DEC_7:   code = 8'hF8;
      DEC_8:   code = 8'h80;
      DEC_9:   code = 8'h90;
      default: code = BLANK_CODE;
    endcase
    return code;
  endfunction

endpackage

### rtl/ssd_ram.sv
// ----------------------------------------------------------------------------
// ssd_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ----------------------------------------------------------------------------
module ssd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/ssd_div10.sv
// ----------------------------------------------------------------------------
// ssd_div10
// Splits off the lowest decimal digit of a 32-bit value by multiplying with
// the reciprocal of ten.
// ----------------------------------------------------------------------------
module ssd_div10
  import ssd_pkg::*;
(
  input  logic [VALUE_W-1:0] value_i,
  output logic [VALUE_W-1:0] quot_o,
  output logic [REM_W-1:0]   rem_o
);

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot;
  logic [VALUE_W-1:0]   times_ten;
  logic [VALUE_W-1:0]   diff;

  always_comb begin
    prod      = {{VALUE_W{1'b0}}, value_i} * {{VALUE_W{1'b0}}, DIV10_MAGIC};
    quot      = VALUE_W'(prod >> DIV10_SHIFT);
    times_ten = (quot << 3) + (quot << 1);
    diff      = value_i - times_ten;
  end

  assign quot_o = quot;
  assign rem_o  = diff[REM_W-1:0];

endmodule

### rtl/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment driver: segment codes live in a small RAM,
// number words fill it one decimal digit per cycle, tick words scan it.
// ----------------------------------------------------------------------------
// Tick word: the scan entry is read into the RAM's read register, then loaded
// into the output register once no stalled result is held; the input waits
// for as long as a stalled result blocks it.
// Number word: stores up to Digits decimal digits, one per cycle, set by the
// divide-by-ten unit and the single RAM write port, then returns to idle.
// Reset clears the scan index and the per-entry valid bits at once, so every
// entry reads as blank straight away; no clearing pass is needed.
module seven_segment_scan_driver
  import ssd_pkg::*;
#(
  parameter int unsigned Digits = DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [VALUE_W-1:0] number_value_i,
  input  logic [START_W-1:0] start_digit_i,
  input  logic [COUNT_W-1:0] digit_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [SEL_W-1:0]   digit_select_o,
  output logic [SEG_W-1:0]   segment_pattern_o
);

  localparam int unsigned IdxW = (Digits > 1) ? $clog2(Digits) : 1;

  typedef enum logic [1:0] {
    StIdle,
    StWrite,
    StRead
  } state_e;

  state_e             state_q;
  logic [IdxW-1:0]    scan_q;
  logic [IdxW-1:0]    rd_idx_q;
  logic               rd_vld_q;
  logic [Digits-1:0]  vld_q;
  logic [VALUE_W-1:0] value_q;
  logic [POS_W-1:0]   pos_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               out_valid_q;
  logic               out_valid_d;
  logic [SEL_W-1:0]   sel_q;
  logic [SEG_W-1:0]   seg_q;

  logic               in_acc;
  logic               tick_acc;
  logic               wr_done;
  logic               ram_we;
  logic [IdxW-1:0]    wr_addr;
  logic [VALUE_W-1:0] quot;
  logic [REM_W-1:0]   rem;
  logic [SEG_W-1:0]   ram_rdata;
  logic               out_free;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  assign tick_acc   = in_acc && (cmd_i == CMD_TICK);
  assign wr_done    = (cnt_q == '0) || (pos_q >= POS_W'(Digits));
  assign ram_we     = (state_q == StWrite) && !wr_done;
  assign wr_addr    = pos_q[IdxW-1:0];
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == StRead) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  ssd_div10 u_div10 (
    .value_i (value_q),
    .quot_o  (quot),
    .rem_o   (rem)
  );

  ssd_ram #(
    .Width (SEG_W),
    .Depth (Digits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i (digit_code(rem)),
    .re_i    (tick_acc),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scan_q      <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      value_q     <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      sel_q       <= '0;
      seg_q       <= BLANK_CODE;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            if (cmd_i == CMD_NUMBER) begin
              value_q <= number_value_i;
              pos_q   <= POS_W'(start_digit_i);
              cnt_q   <= digit_count_i;
              state_q <= StWrite;
            end else begin
              rd_idx_q <= scan_q;
              rd_vld_q <= vld_q[scan_q];
              scan_q   <= (scan_q == IdxW'(Digits - 1)) ? '0 : scan_q + 1'b1;
              state_q  <= StRead;
            end
          end
        end
        StWrite: begin
          if (wr_done) begin
            state_q <= StIdle;
          end else begin
            vld_q[wr_addr] <= 1'b1;
            value_q        <= quot;
            pos_q          <= pos_q + 1'b1;
            cnt_q          <= cnt_q - 1'b1;
          end
        end
        StRead: begin
          if (out_free) begin
            sel_q   <= SEL_W'(1) << rd_idx_q;
            seg_q   <= rd_vld_q ? ram_rdata : BLANK_CODE;
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_select_o    = sel_q;
  assign segment_pattern_o = seg_q;

endmodule

### rtl/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the seven-segment scan driver, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker
  import ssd_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               cmd_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [SEL_W-1:0]   digit_select_o,
  input logic [SEG_W-1:0]   segment_pattern_o
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // A stalled result word holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digit_select_o)
      && $stable(segment_pattern_o))
    else $error("stalled result word changed");

  // At most one digit is enabled in a result word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0(digit_select_o))
    else $error("more than one digit enabled");

  // A number word never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (cmd_i == CMD_NUMBER) |=> !$rose(out_valid_o))
    else $error("result raised by a number word");

  // Every accepted word drops the input ready in the cycle after acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input ready straight after acceptance");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (.*);
